@@ rtl/octant_table_atan2_macros.svh @@
// Assertion macros shared by the octant_table_atan2 RTL.
`ifndef OCTANT_TABLE_ATAN2_MACROS_SVH
`define OCTANT_TABLE_ATAN2_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OTA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("octant_table_atan2 assertion failed");

// Next-cycle implication, disabled during reset.
`define OTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("octant_table_atan2 assertion failed");

`endif

@@ rtl/ota_pkg.sv @@
// Package for octant_table_atan2: widths, sequencer states, tangent table.
`default_nettype none

package ota_pkg;

    localparam int COORD_WIDTH = 18;
    localparam int TAN_ENTRIES = 33;
    localparam int MAG_W       = COORD_WIDTH;
    localparam int RATIO_W     = 14;
    localparam int IDX_W       = 6;
    localparam int ANGLE_W     = 8;
    localparam int CNT_W       = 4;
    localparam int DIV_STEPS   = RATIO_W;
    localparam int SRCH_STEPS  = IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_DIV,
        S_SRCH,
        S_DONE
    } state_t;

    // trunc(tan(i*2*pi/256)*8192); probes past the end read as full scale
    function automatic logic [RATIO_W-1:0] tan_at(input logic [IDX_W-1:0] idx);
        logic [RATIO_W-1:0] v;
        case (idx)
            6'd0:    v = 14'd0;
            6'd1:    v = 14'd201;
            6'd2:    v = 14'd402;
            6'd3:    v = 14'd604;
            6'd4:    v = 14'd806;
            6'd5:    v = 14'd1010;
            6'd6:    v = 14'd1215;
            6'd7:    v = 14'd1421;
            6'd8:    v = 14'd1629;
            6'd9:    v = 14'd1839;
            6'd10:   v = 14'd2051;
            6'd11:   v = 14'd2267;
            6'd12:   v = 14'd2485;
            6'd13:   v = 14'd2706;
            6'd14:   v = 14'd2931;
            6'd15:   v = 14'd3159;
            6'd16:   v = 14'd3393;
            6'd17:   v = 14'd3631;
            6'd18:   v = 14'd3874;
            6'd19:   v = 14'd4123;
            6'd20:   v = 14'd4378;
            6'd21:   v = 14'd4640;
            6'd22:   v = 14'd4910;
            6'd23:   v = 14'd5187;
            6'd24:   v = 14'd5473;
            6'd25:   v = 14'd5769;
            6'd26:   v = 14'd6075;
            6'd27:   v = 14'd6393;
            6'd28:   v = 14'd6723;
            6'd29:   v = 14'd7066;
            6'd30:   v = 14'd7424;
            6'd31:   v = 14'd7799;
            default: v = 14'd8192;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/octant_table_atan2.sv @@
// Top level of octant_table_atan2: binary-angle atan2 of the negated vector.
// Sequence: the magnitude state, the restoring divide and the table search run before m_valid;
// a zero vector goes from the magnitude state straight to the output.
// Throughput: a new word is accepted only after the last result is taken; the shared
// restoring subtractor (one quotient bit a cycle) and the table search probe set the pace.
// Reset: synchronous, active low; returns to idle and drops m_valid.
`default_nettype none

module octant_table_atan2 (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [ota_pkg::COORD_WIDTH-1:0] s_vec_x,
    input  wire logic signed [ota_pkg::COORD_WIDTH-1:0] s_vec_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ota_pkg::ANGLE_W-1:0]              m_angle,
    output logic                                     m_zero_vector
);

`include "octant_table_atan2_macros.svh"

    localparam int CW = ota_pkg::COORD_WIDTH;
    localparam int MW = ota_pkg::MAG_W;
    localparam int RW = ota_pkg::RATIO_W;
    localparam int IW = ota_pkg::IDX_W;
    localparam int AW = ota_pkg::ANGLE_W;
    localparam int NW = ota_pkg::CNT_W;

    ota_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic [MW-1:0]        large_reg, large_next;
    logic [MW:0]          rem_reg, rem_next;
    logic [RW-1:0]        quo_reg, quo_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 xneg_reg, xneg_next;
    logic                 yneg_reg, yneg_next;
    logic                 xley_reg, xley_next;
    logic [AW-1:0]        angle_reg, angle_next;
    logic                 zero_reg, zero_next;

    logic [MW-1:0] mx, my;
    logic          x_le_y;
    logic [MW:0]   diff;
    logic          qbit;
    logic [IW:0]   one_sh;
    logic [IW-1:0] probe;
    logic [IW-1:0] idx_srch;
    logic [AW-1:0] a_ext;
    logic [AW-1:0] fold;

    // magnitudes of the captured components; most negative value maps exactly
    assign mx     = x_reg[CW-1] ? MW'(~x_reg + 1'b1) : MW'(x_reg);
    assign my     = y_reg[CW-1] ? MW'(~y_reg + 1'b1) : MW'(y_reg);
    assign x_le_y = (mx <= my);

    // shared restoring subtractor
    assign diff = rem_reg - {1'b0, large_reg};
    assign qbit = (rem_reg >= {1'b0, large_reg});

    // lower-bound search: probe the last entry of the candidate block
    assign one_sh   = {{IW{1'b0}}, 1'b1} << cnt_reg;
    assign probe    = idx_reg | IW'(one_sh - 1'b1);
    assign idx_srch = (ota_pkg::tan_at(probe) < quo_reg) ? (idx_reg | IW'(one_sh)) : idx_reg;

    // octant fold of the finished index
    assign a_ext = AW'(idx_srch);
    always_comb begin
        case ({xneg_reg, yneg_reg, xley_reg})
            3'b001:  fold = 8'd192 - a_ext;
            3'b000:  fold = 8'd128 + a_ext;
            3'b011:  fold = 8'd64 + a_ext;
            3'b010:  fold = 8'd128 - a_ext;
            3'b101:  fold = 8'd192 + a_ext;
            3'b100:  fold = 8'd0 - a_ext;
            3'b111:  fold = 8'd64 - a_ext;
            default: fold = a_ext;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ota_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        large_reg <= large_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        xley_reg  <= xley_next;
        angle_reg <= angle_next;
        zero_reg  <= zero_next;
    end

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        large_next = large_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        xley_next  = xley_reg;
        angle_next = angle_reg;
        zero_next  = zero_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ota_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    x_next     = s_vec_x;
                    y_next     = s_vec_y;
                    state_next = ota_pkg::S_MAG;
                end
            end
            ota_pkg::S_MAG: begin
                xneg_next  = x_reg[CW-1];
                yneg_next  = y_reg[CW-1];
                xley_next  = x_le_y;
                large_next = x_le_y ? my : mx;
                rem_next   = {1'b0, (x_le_y ? mx : my)};
                quo_next   = '0;
                idx_next   = '0;
                cnt_next   = NW'(ota_pkg::DIV_STEPS - 1);
                if ((x_le_y ? my : mx) == '0) begin
                    angle_next = '0;
                    zero_next  = 1'b1;
                    state_next = ota_pkg::S_DONE;
                end else begin
                    zero_next  = 1'b0;
                    state_next = ota_pkg::S_DIV;
                end
            end
            ota_pkg::S_DIV: begin
                quo_next = {quo_reg[RW-2:0], qbit};
                rem_next = qbit ? {diff[MW-1:0], 1'b0} : {rem_reg[MW-1:0], 1'b0};
                if (cnt_reg == '0) begin
                    cnt_next   = NW'(ota_pkg::SRCH_STEPS - 1);
                    state_next = ota_pkg::S_SRCH;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ota_pkg::S_SRCH: begin
                idx_next = idx_srch;
                if (cnt_reg == '0) begin
                    angle_next = fold;
                    state_next = ota_pkg::S_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ota_pkg::S_DONE: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ota_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ota_pkg::S_IDLE;
            end
        endcase
    end

    assign m_angle       = angle_reg;
    assign m_zero_vector = zero_reg;

    `OTA_ASSERT_IMPL(a_zero_angle, aclk, aresetn, m_valid && m_zero_vector, m_angle == '0)
    `OTA_ASSERT_IMPL(a_one_side, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `OTA_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid)
    `OTA_ASSERT_IMPL(a_rem_bound, aclk, aresetn, state_reg == ota_pkg::S_DIV,
        rem_reg < {large_reg, 1'b0})

endmodule

`default_nettype wire
